// ----- hw/rtl/sha256bc_pkg.sv -----
// ----------------------------------------------------------------------------
// sha256bc_pkg
// Shared types, constants and round functions for the SHA-256 block
// compression engine.
// ----------------------------------------------------------------------------
package sha256bc_pkg;

	localparam int WordW  = 32;
	localparam int NumH   = 8;
	localparam int WinLen = 16;
	localparam int Rounds = 64;
	localparam int RndW   = $clog2(Rounds);
	localparam int PosW   = $clog2(WinLen);
	localparam int CfgIdxW = $clog2(NumH);

	typedef logic [WordW-1:0] word_t;
	// Eight-word vector; index 0 is a (or H0), index 7 is h (or H7).
	typedef logic [NumH-1:0][WordW-1:0] vars_t;

	// Schedule window control from the sequencer.
	typedef struct packed {
		logic load;  // shift in one message word
		logic step;  // shift in the next expanded schedule word
	} sched_ctl_t;

	localparam vars_t STD_INIT = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	localparam word_t ROUND_K [Rounds] = '{
		32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
		32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
		32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
		32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
		32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
		32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
		32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
		32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
		32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
		32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
		32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
		32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
		32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
		32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
		32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
		32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
	};

	function automatic word_t big_sigma0(input word_t x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic word_t big_sigma1(input word_t x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic word_t small_sigma0(input word_t x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic word_t small_sigma1(input word_t x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage

// ----- hw/rtl/sha256_block_compression.sv -----
// ----------------------------------------------------------------------------
// sha256_block_compression
// SHA-256 compression engine fed one 32-bit message word per request.
// ----------------------------------------------------------------------------
// A word that does not complete a block is taken without holding off the input; a
//   word that completes a block holds the input while the 64 rounds run on the
//   shared round unit and the working variables then fold into H.
// An end-of-message request also loads the digest register once it is free.
// No new word is taken while the rounds, the fold or a digest load are in progress.
// Reset: init and chaining registers take the standard initial values, no
//   digest is pending; the schedule window is not cleared.
// ----------------------------------------------------------------------------
module sha256_block_compression import sha256bc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// configuration write port
	input  logic               cfg_write,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  word_t              cfg_data,
	// input requests
	input  logic               in_valid,
	output logic               in_stall,
	input  word_t              message_word,
	input  logic               start_of_message,
	input  logic               end_of_message,
	// digest requests
	output logic               out_valid,
	input  logic               out_stall,
	output word_t              digest_word_0,
	output word_t              digest_word_1,
	output word_t              digest_word_2,
	output word_t              digest_word_3,
	output word_t              digest_word_4,
	output word_t              digest_word_5,
	output word_t              digest_word_6,
	output word_t              digest_word_7
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROUND,
		ST_FINISH,
		ST_EMIT
	} state_t;

	state_t            state_q;
	logic [RndW-1:0]   rnd_q;
	logic [PosW-1:0]   pos_q;
	logic              end_q;
	logic              out_valid_q;
	vars_t             cfg_q;   // initial chaining words
	vars_t             h_q;     // chaining value
	vars_t             v_q;     // working variables a..h
	vars_t             dig_q;   // digest output register
	vars_t             v_next;
	word_t             wr;
	sched_ctl_t        sched_ctl;

	logic              in_accept;
	logic [PosW-1:0]   pos_eff;
	logic              blk_done;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;

	// A start request restarts the block count before the word lands.
	assign pos_eff  = start_of_message ? '0 : pos_q;
	assign blk_done = (pos_eff == PosW'(WinLen - 1));

	assign sched_ctl.load = in_accept;
	assign sched_ctl.step = (state_q == ST_ROUND);

	sha256bc_sched u_sched (
		.clk     (clk),
		.ctl     (sched_ctl),
		.word_in (message_word),
		.wr      (wr)
	);

	sha256bc_round u_round (
		.v      (v_q),
		.wr     (wr),
		.kr     (ROUND_K[rnd_q]),
		.v_next (v_next)
	);

	// Working variables are payload: load at block start, advance per round.
	always_ff @(posedge clk) begin
		if (in_accept && blk_done) begin
			v_q <= start_of_message ? cfg_q : h_q;
		end else if (state_q == ST_ROUND) begin
			v_q <= v_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rnd_q       <= '0;
			pos_q       <= '0;
			end_q       <= 1'b0;
			out_valid_q <= 1'b0;
			cfg_q       <= STD_INIT;
			h_q         <= STD_INIT;
		end else begin
			if (cfg_write) begin
				cfg_q[cfg_index] <= cfg_data;
			end
			// drop the digest once the sink takes it
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						if (start_of_message) begin
							h_q <= cfg_q;
						end
						end_q <= end_of_message;
						if (blk_done || end_of_message) begin
							pos_q <= '0;
						end else begin
							pos_q <= pos_eff + 1'b1;
						end
						if (blk_done) begin
							rnd_q   <= '0;
							state_q <= ST_ROUND;
						end else if (end_of_message) begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 1'b1;
					if (rnd_q == RndW'(Rounds - 1)) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					// fold the working variables into the chaining value
					for (int i = 0; i < NumH; i++) begin
						h_q[i] <= h_q[i] + v_q[i];
					end
					state_q <= end_q ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					// hold until the digest register is free
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Digest register is payload; load it as the emit completes.
	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && (!out_valid_q || !out_stall)) begin
			dig_q <= h_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign digest_word_0 = dig_q[0];
	assign digest_word_1 = dig_q[1];
	assign digest_word_2 = dig_q[2];
	assign digest_word_3 = dig_q[3];
	assign digest_word_4 = dig_q[4];
	assign digest_word_5 = dig_q[5];
	assign digest_word_6 = dig_q[6];
	assign digest_word_7 = dig_q[7];

	// A word that completes a block starts the rounds at round zero.
	a_blk_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && blk_done |=> state_q == ST_ROUND && rnd_q == '0)
		else $error("block completion did not start rounds");

	// The last round always hands over to the fold step.
	a_round_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROUND && rnd_q == RndW'(Rounds - 1) |=> state_q == ST_FINISH)
		else $error("round sequence did not end in fold");

	// A digest only appears from the emit step.
	a_emit_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_EMIT))
		else $error("digest valid raised outside emit");

	// Input is held off for the whole compression.
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROUND || state_q == ST_FINISH |-> in_stall)
		else $error("input taken during compression");

endmodule

// ----- hw/rtl/sha256bc_sched.sv -----
// ----------------------------------------------------------------------------
// sha256bc_sched
// Sixteen-word message schedule window; fills from the input and expands
// one schedule word per round.
// ----------------------------------------------------------------------------
module sha256bc_sched import sha256bc_pkg::*; (
	input  logic       clk,
	input  sched_ctl_t ctl,
	input  word_t      word_in,
	output word_t      wr
);

	// win_q[0] holds the word used in the current round.
	word_t win_q [WinLen];
	word_t w_next;

	assign wr = win_q[0];
	assign w_next = small_sigma1(win_q[14]) + win_q[9] + small_sigma0(win_q[1]) + win_q[0];

	always_ff @(posedge clk) begin
		if (ctl.load || ctl.step) begin
			for (int i = 0; i < WinLen - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[WinLen-1] <= ctl.load ? word_in : w_next;
		end
	end

endmodule

// ----- hw/rtl/sha256bc_round.sv -----
// ----------------------------------------------------------------------------
// sha256bc_round
// One SHA-256 round: working variables in, updated working variables out.
// ----------------------------------------------------------------------------
module sha256bc_round import sha256bc_pkg::*; (
	input  vars_t v,
	input  word_t wr,
	input  word_t kr,
	output vars_t v_next
);

	word_t t1;
	word_t t2;
	word_t ch;
	word_t maj;

	assign ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
	assign maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
	assign t1  = v[7] + big_sigma1(v[4]) + ch + kr + wr;
	assign t2  = big_sigma0(v[0]) + maj;

	always_comb begin
		v_next[0] = t1 + t2;
		v_next[1] = v[0];
		v_next[2] = v[1];
		v_next[3] = v[2];
		v_next[4] = v[3] + t1;
		v_next[5] = v[4];
		v_next[6] = v[5];
		v_next[7] = v[6];
	end

endmodule

// ----- test/tb_sha256_block_compression.sv -----
// ----------------------------------------------------------------------------
// tb_sha256_block_compression
// Feeds message words into the SHA-256 block compression engine under random
// input gaps and output stalls. A cycle-free software model of the chaining
// value predicts every digest. Each digest request that leaves the block is
// compared word by word against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_sha256_block_compression;
	import sha256bc_pkg::*;

	localparam int          CLK_PERIOD     = 8;
	localparam int          DRAIN_CYCLES   = 80;       // one block of rounds plus margin
	localparam int          HOLD_CYCLES    = 400;      // long receiver hold-off
	localparam int unsigned GAP_PCT        = 19;
	localparam longint      TIMEOUT_CYCLES = 1000000;

	typedef enum logic [CfgIdxW-1:0] {
		INIT_H0, INIT_H1, INIT_H2, INIT_H3, INIT_H4, INIT_H5, INIT_H6, INIT_H7
	} init_reg_e;

	// Standard initial hash words, word 0 in the low slot.
	localparam vars_t IV_WORDS = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	// Known digest of the one-block message "abc".
	localparam vars_t ABC_DIGEST = {
		32'hf20015ad, 32'hb410ff61, 32'h96177a9c, 32'hb00361a3,
		32'h5dae2223, 32'h414140de, 32'h8f01cfea, 32'hba7816bf
	};

	localparam word_t ROUND_CONST [64] = '{
		32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
		32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
		32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
		32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
		32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
		32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
		32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
		32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
		32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
		32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
		32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
		32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
		32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
		32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
		32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
		32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
	};

	// DUT-facing signals; every input starts at a known value.
	logic               clk              = 1'b0;
	logic               arst_n           = 1'b0;
	logic               cfg_write        = 1'b0;
	logic [CfgIdxW-1:0] cfg_index        = '0;
	word_t              cfg_data         = '0;
	logic               in_valid         = 1'b0;
	logic               in_stall;
	word_t              message_word     = '0;
	logic               start_of_message = 1'b0;
	logic               end_of_message   = 1'b0;
	logic               out_valid;
	logic               out_stall        = 1'b0;
	word_t              digest_word_0, digest_word_1, digest_word_2, digest_word_3;
	word_t              digest_word_4, digest_word_5, digest_word_6, digest_word_7;

	// Model of the chaining state.
	vars_t       model_init  = IV_WORDS;
	vars_t       model_chain = IV_WORDS;
	word_t       block_words [16];
	int unsigned block_fill  = 0;
	vars_t       pending_digests [$];

	// Traffic shaping, written only by the test sequence.
	int unsigned send_gap_pct  = GAP_PCT;
	int unsigned stall_pct     = GAP_PCT;
	int unsigned hold_requests = 0;

	// Receiver bookkeeping.
	int unsigned hold_served = 0;
	int unsigned hold_left   = 0;
	vars_t       digest_seen;
	vars_t       digest_want;

	int unsigned words_sent     = 0;
	int unsigned digests_seen   = 0;
	int unsigned init_loads     = 0;
	int unsigned mismatches     = 0;

	sha256_block_compression u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write        (cfg_write),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.message_word     (message_word),
		.start_of_message (start_of_message),
		.end_of_message   (end_of_message),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.digest_word_0    (digest_word_0),
		.digest_word_1    (digest_word_1),
		.digest_word_2    (digest_word_2),
		.digest_word_3    (digest_word_3),
		.digest_word_4    (digest_word_4),
		.digest_word_5    (digest_word_5),
		.digest_word_6    (digest_word_6),
		.digest_word_7    (digest_word_7)
	);

	assign digest_seen = {digest_word_7, digest_word_6, digest_word_5, digest_word_4,
		digest_word_3, digest_word_2, digest_word_1, digest_word_0};

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic word_t rotr32(input word_t x, input int unsigned n);
		return (x >> n) | (x << (WordW - n));
	endfunction

	// Mostly random words, with the all-zero and all-one extremes mixed in.
	function automatic word_t random_word();
		if ($urandom_range(7) == 0)
			return $urandom_range(1) ? '1 : '0;
		return $urandom;
	endfunction

	// Advance the model by one accepted word: reload on start, buffer the word,
	// compress on the sixteenth word, and queue the chaining value on end.
	task automatic absorb_word(input word_t word, input bit sop, input bit eop);
		word_t w [16];
		word_t v [8];
		word_t s0, s1, t1, t2, wr, x1, x14;
		if (sop) begin
			model_chain = model_init;
			block_fill  = 0;
		end
		block_words[block_fill] = word;
		block_fill++;
		if (block_fill == WinLen) begin
			w = block_words;
			for (int k = 0; k < NumH; k++)
				v[k] = model_chain[k];
			for (int r = 0; r < Rounds; r++) begin
				if (r < WinLen) begin
					wr = w[r];
				end else begin
					// Rolling 16-entry schedule window.
					x1  = w[(r + 1) % WinLen];
					x14 = w[(r + 14) % WinLen];
					s0  = rotr32(x1, 7) ^ rotr32(x1, 18) ^ (x1 >> 3);
					s1  = rotr32(x14, 17) ^ rotr32(x14, 19) ^ (x14 >> 10);
					wr  = w[r % WinLen] + s0 + s1 + w[(r + 9) % WinLen];
					w[r % WinLen] = wr;
				end
				t1 = v[7] + (rotr32(v[4], 6) ^ rotr32(v[4], 11) ^ rotr32(v[4], 25))
					+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[r] + wr;
				t2 = (rotr32(v[0], 2) ^ rotr32(v[0], 13) ^ rotr32(v[0], 22))
					+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
				for (int k = 7; k > 0; k--)
					v[k] = v[k - 1];
				v[4] = v[4] + t1;
				v[0] = t1 + t2;
			end
			for (int k = 0; k < NumH; k++)
				model_chain[k] = model_chain[k] + v[k];
			block_fill = 0;
		end
		if (eop) begin
			pending_digests.push_back(model_chain);
			block_fill = 0;
		end
	endtask

	// Offer one word and hold it until the block takes it.
	task automatic send_word(input word_t word, input bit sop, input bit eop);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid         <= 1'b1;
		message_word     <= word;
		start_of_message <= sop;
		end_of_message   <= eop;
		do
			@(posedge clk);
		while (in_stall);
		absorb_word(word, sop, eop);
		words_sent++;
	endtask

	// Random words, end flag on the last one, start flag on the first if asked.
	task automatic send_message(input int unsigned n_words, input bit with_start);
		for (int i = 0; i < n_words; i++)
			send_word(random_word(), with_start && i == 0, i == n_words - 1);
	endtask

	// Drop valid, drain every predicted digest, then let any block still in its
	// rounds finish, since a word that ends no message leaves no digest to wait on.
	task automatic wait_for_idle();
		in_valid <= 1'b0;
		while (pending_digests.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write all eight initial hash registers, one per cycle.
	task automatic load_init_words(input vars_t iv);
		init_reg_e reg_idx;
		reg_idx = INIT_H0;
		repeat (NumH) begin
			cfg_write <= 1'b1;
			cfg_index <= reg_idx;
			cfg_data  <= iv[reg_idx];
			@(posedge clk);
			model_init[reg_idx] = iv[reg_idx];
			reg_idx = reg_idx.next();
		end
		cfg_write <= 1'b0;
		init_loads++;
	endtask

	// Directed corner cases on the reset values of the init registers.
	task automatic test_directed();
		// "abc" padded to one block; cross-check the model against the known hash.
		send_word(32'h61626380, 1'b1, 1'b0);
		repeat (14) send_word('0, 1'b0, 1'b0);
		send_word(32'h00000018, 1'b0, 1'b1);
		if (pending_digests[$] != ABC_DIGEST) begin
			$error("model digest of abc: expected %h, got %h", ABC_DIGEST, pending_digests[$]);
			mismatches++;
		end
		// Start and end on one word: the loaded init words come straight back.
		send_word('1, 1'b1, 1'b1);
		// End with no start: report whatever chaining value is current.
		send_word('0, 1'b0, 1'b1);
		// Partial block at end: the held words are dropped, no rounds run.
		send_word('1, 1'b1, 1'b0);
		send_word('0, 1'b0, 1'b0);
		send_word(32'h80000001, 1'b0, 1'b1);
		// Leave a partial block pending; the next start must discard it.
		send_word(32'h7FFFFFFE, 1'b0, 1'b0);
		send_word(32'hA5A5A5A5, 1'b0, 1'b0);
		send_message(16, 1'b1);
	endtask

	// Sweep the init registers through extremes, an alternating pattern, a random set and back.
	task automatic test_init_vectors();
		vars_t iv;
		for (int s = 0; s < 5; s++) begin
			case (s)
				0: iv = '0;
				1: iv = '1;
				2: iv = {NumH{32'hAAAAAAAA}} ^ {4{32'h00000000, 32'hFFFFFFFF}};
				3: for (int k = 0; k < NumH; k++) iv[k] = $urandom;
				default: iv = IV_WORDS;
			endcase
			wait_for_idle();
			load_init_words(iv);
			send_message(16, 1'b1);
			send_message(1, 1'b1);
			send_message(16, 1'b0);
		end
	endtask

	// Hold the output for a long stretch while words keep coming, so the
	// digest path backs up into the input.
	task automatic test_output_holdoff();
		hold_requests <= hold_requests + 1;
		repeat (10) send_message(1, 1'b1);
		send_message(16, 1'b1);
		send_message(32, 1'b1);
	endtask

	// Bulk traffic: mostly well-formed messages with random content, mixed with
	// chained blocks, dropped tails, one-word messages, loose words and flag noise.
	task automatic test_random_traffic(input int unsigned word_target);
		int unsigned kind;
		int unsigned n_msgs;
		vars_t       iv;
		n_msgs = 0;
		while (words_sent < word_target) begin
			kind = $urandom_range(99);
			if (kind < 60)
				send_message(16 * $urandom_range(1, 2), 1'b1);
			else if (kind < 68)
				send_message(16 * $urandom_range(1, 3), 1'b0);
			else if (kind < 78)
				send_message(16 * $urandom_range(0, 1) + $urandom_range(1, 15), 1'b1);
			else if (kind < 86)
				send_message(1, 1'b1);
			else if (kind < 93)
				repeat ($urandom_range(1, 15)) send_word(random_word(), 1'b0, 1'b0);
			else
				repeat ($urandom_range(1, 8))
					send_word(random_word(), $urandom_range(5) == 0, $urandom_range(5) == 0);
			n_msgs++;
			if (n_msgs % 24 == 0) begin
				for (int k = 0; k < NumH; k++)
					iv[k] = random_word();
				wait_for_idle();
				load_init_words(iv);
			end
		end
	endtask

	// Back-to-back traffic with neither side idling.
	task automatic test_full_rate();
		send_gap_pct <= 0;
		stall_pct    <= 0;
		repeat (4) send_message(16, 1'b1);
		repeat (2) send_message(32, 1'b1);
		send_gap_pct <= GAP_PCT;
		stall_pct    <= GAP_PCT;
	endtask

	// Digest receiver: check each accepted request, then pick the next stall.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				digests_seen++;
				if (pending_digests.size() == 0) begin
					$error("digest request with no prediction waiting: %h", digest_seen);
					mismatches++;
				end else begin
					digest_want = pending_digests.pop_front();
					for (int i = 0; i < NumH; i++)
						if (digest_seen[i] !== digest_want[i]) begin
							$error("digest_word_%0d: expected %h, got %h",
								i, digest_want[i], digest_seen[i]);
							mismatches++;
						end
				end
			end
			// Start a long hold when the sequence asks for one.
			if (hold_served != hold_requests) begin
				hold_served = hold_requests;
				hold_left   = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_init_vectors();
		test_output_holdoff();
		test_random_traffic(1680);
		test_full_rate();

		// Drain outstanding digests and give the block time for a stray request.
		wait_for_idle();

		$display("%0d words sent, %0d digests checked, %0d init register loads",
			words_sent, digests_seen, init_loads);
		$display("covered corner flags, init extremes, output hold-off, full rate, random mix");
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("simulation failed");
		$finish;
	end

endmodule
